[hdl/mtfl_pkg.sv]
// Package for the move-to-front list: request and status codes, controller
// command codes and the command / status structs between controller and datapath.
// No dependencies.
package mtfl_pkg;

   // Request kinds
   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_SEARCH = 2'd1;
   localparam logic [1:0] KIND_ERASE  = 2'd2;

   // Result status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_MISS  = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [1:0] ST_RANGE = 2'd3;

   // Index counter operations
   localparam logic [2:0] IDX_HOLD = 3'd0;
   localparam logic [2:0] IDX_OCC  = 3'd1;
   localparam logic [2:0] IDX_ZERO = 3'd2;
   localparam logic [2:0] IDX_POS  = 3'd3;
   localparam logic [2:0] IDX_INC  = 3'd4;
   localparam logic [2:0] IDX_DEC  = 3'd5;

   // Shift target operations
   localparam logic [1:0] TGT_HOLD   = 2'd0;
   localparam logic [1:0] TGT_INSERT = 2'd1;
   localparam logic [1:0] TGT_ZERO   = 2'd2;

   // Read address select, relative to the index counter
   localparam logic [1:0] RD_HERE = 2'd0;
   localparam logic [1:0] RD_DOWN = 2'd1;
   localparam logic [1:0] RD_UP   = 2'd2;

   // Write select
   localparam logic WR_SHIFT = 1'b0;  // entries[idx] <= read word
   localparam logic WR_PUT   = 1'b1;  // entries[tgt] <= key

   typedef struct packed {
      logic       load;
      logic [2:0] idx_op;
      logic [1:0] tgt_op;
      logic       rd_en;
      logic [1:0] rd_sel;
      logic       wr_en;
      logic       wr_sel;
      logic       occ_inc;
      logic       occ_dec;
      logic       found_load;
      logic       rsp_load;
      logic [1:0] rsp_status;
      logic       rsp_hit;
   } cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       full;
      logic       ins_range;
      logic       era_range;
      logic       idx_gt_tgt;
      logic       idx_lt_occ;
      logic       up_lt_occ;
      logic       hit;
   } stat_type;

endpackage

[hdl/mtfl_dp.sv]
// Datapath of the move-to-front list: entry memory, occupancy, index and
// target counters, key compare and the result register.
// Depends on mtfl_pkg.
module mtfl_dp
   import mtfl_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output stat_type           stat,
   input  logic [1:0]         req_type,
   input  logic signed [31:0] key_value,
   input  logic [6:0]         position,
   input  logic               at_tail,
   output logic [1:0]         status,
   output logic [5:0]         found_index,
   output logic [6:0]         entry_count
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = (CW > 7) ? CW : 7;
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

   logic [31:0]        entries_ff [CAPACITY];
   logic [31:0]        rd_data_ff;
   logic [CW-1:0]      occ_ff, occ_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [CW-1:0]      tgt_ff, tgt_in;
   logic [5:0]         found_ff;
   logic [1:0]         kind_ff;
   logic signed [31:0] key_ff;
   logic [6:0]         pos_ff;
   logic               tail_ff;
   logic [1:0]         rsp_status_ff;
   logic [5:0]         rsp_found_ff;
   logic [6:0]         rsp_count_ff;

   logic [CW:0]        up_idx;
   logic [CW-1:0]      rd_idx;
   logic [AW-1:0]      rd_addr;
   logic [AW-1:0]      wr_addr;
   logic [31:0]        wr_data;

   // Captured request fields
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_type;
         key_ff  <= key_value;
         pos_ff  <= position;
         tail_ff <= at_tail;
      end
   end

   // Counter next values
   always_comb begin
      case (cmd.idx_op)
         IDX_OCC:  idx_in = occ_ff;
         IDX_ZERO: idx_in = '0;
         IDX_POS:  idx_in = CW'(pos_ff);
         IDX_INC:  idx_in = idx_ff + 1'b1;
         IDX_DEC:  idx_in = idx_ff - 1'b1;
         default:  idx_in = idx_ff;
      endcase
      case (cmd.tgt_op)
         TGT_INSERT: tgt_in = tail_ff ? occ_ff : CW'(pos_ff);
         TGT_ZERO:   tgt_in = '0;
         default:    tgt_in = tgt_ff;
      endcase
      occ_in = occ_ff;
      if (cmd.occ_inc) begin
         occ_in = occ_ff + 1'b1;
      end else if (cmd.occ_dec) begin
         occ_in = occ_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      tgt_ff <= tgt_in;
      if (cmd.found_load) begin
         found_ff <= 6'(idx_ff);
      end
   end

   // Memory addressing
   always_comb begin
      up_idx = {1'b0, idx_ff} + 1'b1;
      case (cmd.rd_sel)
         RD_DOWN: rd_idx = idx_ff - 1'b1;
         RD_UP:   rd_idx = up_idx[CW-1:0];
         default: rd_idx = idx_ff;
      endcase
      rd_addr = rd_idx[AW-1:0];
      wr_addr = (cmd.wr_sel == WR_PUT) ? tgt_ff[AW-1:0] : idx_ff[AW-1:0];
      wr_data = (cmd.wr_sel == WR_PUT) ? key_ff : rd_data_ff;
   end

   // Entry memory, one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         entries_ff[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= entries_ff[rd_addr];
      end
   end

   // Status flags to the controller
   always_comb begin
      stat.kind       = kind_ff;
      stat.full       = (occ_ff >= CAP_C);
      stat.ins_range  = !tail_ff && (XW'(pos_ff) > XW'(occ_ff));
      stat.era_range  = (XW'(pos_ff) >= XW'(occ_ff));
      stat.idx_gt_tgt = (idx_ff > tgt_ff);
      stat.idx_lt_occ = (idx_ff < occ_ff);
      stat.up_lt_occ  = (up_idx < {1'b0, occ_ff});
      stat.hit        = (rd_data_ff == key_ff);
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_status_ff <= cmd.rsp_status;
         rsp_found_ff  <= cmd.rsp_hit ? found_ff : '0;
         rsp_count_ff  <= 7'(occ_ff);
      end
   end

   assign status      = rsp_status_ff;
   assign found_index = rsp_found_ff;
   assign entry_count = rsp_count_ff;

   // Checks
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CAP_C)
      else $error("occupancy above capacity");

   a_occ_step: assert property (@(posedge clock) disable iff (reset)
      occ_ff != $past(occ_ff) |->
         (occ_ff == $past(occ_ff) + 1'b1) || (occ_ff == $past(occ_ff) - 1'b1))
      else $error("occupancy moved by more than one");

   a_shift_addr: assert property (@(posedge clock) disable iff (reset)
      (cmd.wr_en && cmd.wr_sel == WR_SHIFT) |-> (idx_ff < CAP_C))
      else $error("shift write beyond capacity");

endmodule

[hdl/mtfl_ctrl.sv]
// Controller of the move-to-front list: sequences insert, search / move to
// front and erase over the datapath, and owns the stream handshakes.
// Depends on mtfl_pkg.
module mtfl_ctrl
   import mtfl_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   output logic     rsp_tvalid,
   input  logic     rsp_tready,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DECODE   = 4'd1;
   localparam logic [3:0] S_SHIFT_RD = 4'd2;
   localparam logic [3:0] S_SHIFT_WR = 4'd3;
   localparam logic [3:0] S_SCAN_RD  = 4'd4;
   localparam logic [3:0] S_SCAN_CMP = 4'd5;
   localparam logic [3:0] S_ERASE_RD = 4'd6;
   localparam logic [3:0] S_ERASE_WR = 4'd7;
   localparam logic [3:0] S_DONE     = 4'd8;

   logic [3:0] state_ff, state_in;
   logic [1:0] status_ff, status_in;
   logic       hit_ff, hit_in;
   logic       rsp_tvalid_ff, rsp_tvalid_in;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;

   // Next state and datapath commands
   always_comb begin
      state_in  = state_ff;
      status_in = status_ff;
      hit_in    = hit_ff;
      cmd       = '0;
      cmd.idx_op     = IDX_HOLD;
      cmd.tgt_op     = TGT_HOLD;
      cmd.rsp_status = status_ff;
      cmd.rsp_hit    = hit_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            hit_in = 1'b0;
            case (stat.kind)
               KIND_INSERT: begin
                  if (stat.full) begin
                     status_in = ST_FULL;
                     state_in  = S_DONE;
                  end else if (stat.ins_range) begin
                     status_in = ST_RANGE;
                     state_in  = S_DONE;
                  end else begin
                     cmd.idx_op = IDX_OCC;
                     cmd.tgt_op = TGT_INSERT;
                     state_in   = S_SHIFT_RD;
                  end
               end
               KIND_SEARCH: begin
                  cmd.idx_op = IDX_ZERO;
                  cmd.tgt_op = TGT_ZERO;
                  state_in   = S_SCAN_RD;
               end
               KIND_ERASE: begin
                  if (stat.era_range) begin
                     status_in = ST_RANGE;
                     state_in  = S_DONE;
                  end else begin
                     cmd.idx_op = IDX_POS;
                     state_in   = S_ERASE_RD;
                  end
               end
               default: begin
                  status_in = ST_RANGE;
                  state_in  = S_DONE;
               end
            endcase
         end
         // shift toward the back down to the target, then drop the key in
         S_SHIFT_RD: begin
            if (stat.idx_gt_tgt) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_DOWN;
               state_in   = S_SHIFT_WR;
            end else begin
               cmd.wr_en   = 1'b1;
               cmd.wr_sel  = WR_PUT;
               cmd.occ_inc = (stat.kind == KIND_INSERT);
               hit_in      = (stat.kind == KIND_SEARCH);
               status_in   = ST_OK;
               state_in    = S_DONE;
            end
         end
         S_SHIFT_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_SHIFT;
            cmd.idx_op = IDX_DEC;
            state_in   = S_SHIFT_RD;
         end
         // linear scan from the front for the first match
         S_SCAN_RD: begin
            if (stat.idx_lt_occ) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_HERE;
               state_in   = S_SCAN_CMP;
            end else begin
               status_in = ST_MISS;
               state_in  = S_DONE;
            end
         end
         S_SCAN_CMP: begin
            if (stat.hit) begin
               cmd.found_load = 1'b1;
               state_in       = S_SHIFT_RD;
            end else begin
               cmd.idx_op = IDX_INC;
               state_in   = S_SCAN_RD;
            end
         end
         // close the gap by pulling later entries forward
         S_ERASE_RD: begin
            if (stat.up_lt_occ) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_UP;
               state_in   = S_ERASE_WR;
            end else begin
               cmd.occ_dec = 1'b1;
               status_in   = ST_OK;
               state_in    = S_DONE;
            end
         end
         S_ERASE_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_SHIFT;
            cmd.idx_op = IDX_INC;
            state_in   = S_ERASE_RD;
         end
         // wait for the result register to be free
         S_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Result valid flag
   always_comb begin
      if (cmd.rsp_load) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end else begin
         rsp_tvalid_in = rsp_tvalid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_tvalid_ff <= 1'b0;
         status_ff     <= ST_OK;
         hit_ff        <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         status_ff     <= status_in;
         hit_ff        <= hit_in;
      end
   end

   // Checks
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while busy");

   a_valid_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> ($past(state_ff) == S_DONE))
      else $error("result raised outside done");

   a_load_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_tvalid_ff || rsp_tready))
      else $error("result overwritten before taken");

endmodule

[hdl/move_to_front_list.sv]
// One word at a time: each entry move is a read then a write on the
// entry memory. The next request is taken once the result is in the output register.
// Synchronous active-high reset empties the list; entry contents are not cleared.
module move_to_front_list
   import mtfl_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // key_value[31:0], position[38:32], zero pad
   input  logic [2:0]  req_tuser,   // req_type[1:0], at_tail[2]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // found_index[5:0], entry_count[12:6], zero pad
   output logic [1:0]  rsp_tuser    // status[1:0]
);

   cmd_type     cmd;
   stat_type    stat;
   logic [1:0]  status;
   logic [5:0]  found_index;
   logic [6:0]  entry_count;

   mtfl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   mtfl_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_type    (req_tuser[1:0]),
      .key_value   (req_tdata[31:0]),
      .position    (req_tdata[38:32]),
      .at_tail     (req_tuser[2]),
      .status      (status),
      .found_index (found_index),
      .entry_count (entry_count)
   );

   // Result word packing
   assign rsp_tdata = {3'b000, entry_count, found_index};
   assign rsp_tuser = status;

endmodule
